[rtl/alc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package alc_pkg;

    localparam int WINDOW_DEPTH = 8;
    localparam int CURVE_POINTS = 12;
    localparam int CURVE_MAX    = 16;

    localparam int SAMPLE_W  = 16;
    localparam int DB_W      = 8;
    localparam int DUTY_W    = 9;
    localparam int TOTAL_W   = 19;
    localparam int SUM_MAX_W = 22;
    localparam int SEG_W     = 4;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;

    localparam logic REG_CEILING  = 1'b0;
    localparam logic REG_DEADBAND = 1'b1;

    localparam logic [SAMPLE_W-1:0] CEILING_RST  = 16'hFFFF;
    localparam logic [DB_W-1:0]     DEADBAND_RST = 8'd4;

    typedef struct packed {
        logic [SAMPLE_W-1:0] ceiling;
        logic [DB_W-1:0]     deadband;
    } t_cfg;

    typedef enum logic [1:0] {
        T_IDLE,
        T_WIN,
        T_INTERP,
        T_HOLD
    } t_top_state;

    typedef enum logic {
        W_IDLE,
        W_UPDATE
    } t_win_state;

    typedef enum logic [1:0] {
        I_IDLE,
        I_SEARCH,
        I_MUL,
        I_DIV
    } t_int_state;

    // breakpoints of the curve, sensor sum axis
    function automatic logic [SAMPLE_W-1:0] curve_x(input logic [SEG_W-1:0] idx);
        logic [SAMPLE_W-1:0] v;
        case (idx)
            4'd0:    v = 16'd800;
            4'd1:    v = 16'd3400;
            4'd2:    v = 16'd4100;
            4'd3:    v = 16'd6200;
            4'd4:    v = 16'd8200;
            4'd5:    v = 16'd10100;
            4'd6:    v = 16'd20300;
            4'd7:    v = 16'd31500;
            4'd8:    v = 16'd44000;
            4'd9:    v = 16'd53800;
            4'd10:   v = 16'd57600;
            4'd11:   v = 16'd61800;
            4'd12:   v = 16'd63000;
            4'd13:   v = 16'd64000;
            4'd14:   v = 16'd65000;
            default: v = 16'd65535;
        endcase
        return v;
    endfunction

    // duty at each breakpoint
    function automatic logic [DUTY_W-1:0] curve_y(input logic [SEG_W-1:0] idx);
        logic [DUTY_W-1:0] v;
        case (idx)
            4'd0:    v = 9'd18;
            4'd1:    v = 9'd34;
            4'd2:    v = 9'd38;
            4'd3:    v = 9'd50;
            4'd4:    v = 9'd62;
            4'd5:    v = 9'd74;
            4'd6:    v = 9'd135;
            4'd7:    v = 9'd202;
            4'd8:    v = 9'd277;
            4'd9:    v = 9'd336;
            4'd10:   v = 9'd359;
            4'd11:   v = 9'd392;
            4'd12:   v = 9'd400;
            4'd13:   v = 9'd420;
            4'd14:   v = 9'd450;
            default: v = 9'd480;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/alc_window.sv]
`timescale 1ns / 1ps
`default_nettype none

module alc_window #(
    parameter int WINDOW_DEPTH = alc_pkg::WINDOW_DEPTH,
    parameter int SUM_W        = alc_pkg::SAMPLE_W + $clog2(WINDOW_DEPTH)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [alc_pkg::SAMPLE_W-1:0]  i_sample,
    input  wire alc_pkg::t_cfg                 i_cfg,
    output logic                               o_done,
    output logic [SUM_W-1:0]                   o_sum
);

    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

    alc_pkg::t_win_state r_state, n_state;
    logic [alc_pkg::SAMPLE_W-1:0] r_mem [WINDOW_DEPTH];
    logic [alc_pkg::SAMPLE_W-1:0] r_rd;
    logic [WINDOW_DEPTH-1:0]      r_valid, n_valid;
    logic [SUM_W-1:0]             r_sum, n_sum;
    logic [SLOT_W-1:0]            r_slot, n_slot;
    logic                         r_skip, n_skip;
    logic                         r_done, n_done;

    logic [alc_pkg::SAMPLE_W-1:0] old_val;
    logic [alc_pkg::SAMPLE_W-1:0] clamped;
    logic [alc_pkg::SAMPLE_W-1:0] mag;
    logic                         take;

    // entries never written read as zero
    assign old_val = r_valid[r_slot] ? r_rd : '0;
    assign clamped = (i_sample > i_cfg.ceiling) ? i_cfg.ceiling : i_sample;
    assign mag     = (clamped >= old_val) ? clamped - old_val : old_val - clamped;
    assign take    = (mag >= {{(alc_pkg::SAMPLE_W - alc_pkg::DB_W){1'b0}}, i_cfg.deadband});

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        n_sum   = r_sum;
        n_slot  = r_slot;
        n_skip  = r_skip;
        n_done  = 1'b0;
        case (r_state)
            alc_pkg::W_IDLE: begin
                if (i_start) begin
                    if (r_skip) begin
                        n_skip = 1'b0;
                        n_done = 1'b1;
                    end else begin
                        n_state = alc_pkg::W_UPDATE;
                    end
                end
            end
            alc_pkg::W_UPDATE: begin
                if (take) begin
                    n_sum           = r_sum - SUM_W'(old_val) + SUM_W'(clamped);
                    n_valid[r_slot] = 1'b1;
                end
                n_slot  = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
                n_skip  = 1'b1;
                n_done  = 1'b1;
                n_state = alc_pkg::W_IDLE;
            end
            default: n_state = alc_pkg::W_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= alc_pkg::W_IDLE;
            r_valid <= '0;
            r_sum   <= '0;
            r_slot  <= '0;
            r_skip  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_sum   <= n_sum;
            r_slot  <= n_slot;
            r_skip  <= n_skip;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == alc_pkg::W_UPDATE && take) begin
            r_mem[r_slot] <= clamped;
        end
        r_rd <= r_mem[r_slot];
    end

    assign o_done = r_done;
    assign o_sum  = r_sum;

    // every finished word flips the phase
    a_skip_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_skip != $past(r_skip))
        else $error("skip phase did not toggle");

endmodule

`default_nettype wire

[rtl/alc_interp.sv]
`timescale 1ns / 1ps
`default_nettype none

module alc_interp #(
    parameter int SUM_W = alc_pkg::SAMPLE_W + $clog2(alc_pkg::WINDOW_DEPTH)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [SUM_W-1:0]            i_sum,
    output logic                             o_done,
    output logic [alc_pkg::DUTY_W-1:0]       o_duty
);

    localparam int XW    = alc_pkg::SAMPLE_W;
    localparam int YW    = alc_pkg::DUTY_W;
    localparam int SW    = alc_pkg::SEG_W;
    localparam int PW    = XW + YW;
    localparam int CNT_W = $clog2(YW);
    localparam logic [SW-1:0]    LAST_PT  = SW'(alc_pkg::CURVE_POINTS - 1);
    localparam logic [SW-1:0]    LAST_SEG = SW'(alc_pkg::CURVE_POINTS - 2);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(YW - 1);

    alc_pkg::t_int_state r_state, n_state;
    logic [SUM_W-1:0] r_s, n_s;
    logic [SW-1:0]    r_seg, n_seg;
    logic [YW-1:0]    r_y0, n_y0;
    logic [YW-1:0]    r_dy, n_dy;
    logic             r_down, n_down;
    logic [XW-1:0]    r_diff, n_diff;
    logic [XW-1:0]    r_dx, n_dx;
    logic [XW-1:0]    r_rem, n_rem;
    logic [YW-1:0]    r_low, n_low;
    logic [YW-1:0]    r_quo, n_quo;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_done, n_done;
    logic [YW-1:0]    r_duty, n_duty;

    logic [XW-1:0] x0, x1;
    logic [YW-1:0] y0, y1;
    logic          hit;
    logic [PW-1:0] prod;
    logic [XW:0]   trial;
    logic          ge;
    logic [YW-1:0] quo_next;

    assign x0  = alc_pkg::curve_x(r_seg);
    assign x1  = alc_pkg::curve_x(r_seg + 1'b1);
    assign y0  = alc_pkg::curve_y(r_seg);
    assign y1  = alc_pkg::curve_y(r_seg + 1'b1);
    assign hit = (x1 > x0) && (r_s >= SUM_W'(x0)) && (r_s < SUM_W'(x1));

    assign prod     = PW'(r_dy) * PW'(r_diff);
    // restoring divide, one quotient bit a cycle
    assign trial    = {r_rem, r_low[YW-1]};
    assign ge       = (trial >= {1'b0, r_dx});
    assign quo_next = {r_quo[YW-2:0], ge};

    always_comb begin
        n_state = r_state;
        n_s     = r_s;
        n_seg   = r_seg;
        n_y0    = r_y0;
        n_dy    = r_dy;
        n_down  = r_down;
        n_diff  = r_diff;
        n_dx    = r_dx;
        n_rem   = r_rem;
        n_low   = r_low;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_duty  = r_duty;
        n_done  = 1'b0;
        case (r_state)
            alc_pkg::I_IDLE: begin
                if (i_start) begin
                    n_s = i_sum;
                    if (i_sum <= SUM_W'(alc_pkg::curve_x('0))) begin
                        n_duty = alc_pkg::curve_y('0);
                        n_done = 1'b1;
                    end else if (i_sum >= SUM_W'(alc_pkg::curve_x(LAST_PT))) begin
                        n_duty = alc_pkg::curve_y(LAST_PT);
                        n_done = 1'b1;
                    end else begin
                        n_seg   = '0;
                        n_state = alc_pkg::I_SEARCH;
                    end
                end
            end
            alc_pkg::I_SEARCH: begin
                if (hit) begin
                    n_y0    = y0;
                    n_down  = (y1 < y0);
                    n_dy    = (y1 < y0) ? y0 - y1 : y1 - y0;
                    n_diff  = XW'(r_s - SUM_W'(x0));
                    n_dx    = x1 - x0;
                    n_state = alc_pkg::I_MUL;
                end else if (r_seg == LAST_SEG) begin
                    n_duty  = alc_pkg::curve_y(LAST_PT);
                    n_done  = 1'b1;
                    n_state = alc_pkg::I_IDLE;
                end else begin
                    n_seg = r_seg + 1'b1;
                end
            end
            alc_pkg::I_MUL: begin
                // quotient stays below dy, so the top bits start below dx
                n_rem   = prod[PW-1:YW];
                n_low   = prod[YW-1:0];
                n_quo   = '0;
                n_cnt   = '0;
                n_state = alc_pkg::I_DIV;
            end
            alc_pkg::I_DIV: begin
                n_rem = ge ? XW'(trial - {1'b0, r_dx}) : trial[XW-1:0];
                n_low = {r_low[YW-2:0], 1'b0};
                n_quo = quo_next;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_BIT) begin
                    n_duty  = r_down ? r_y0 - quo_next : r_y0 + quo_next;
                    n_done  = 1'b1;
                    n_state = alc_pkg::I_IDLE;
                end
            end
            default: n_state = alc_pkg::I_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= alc_pkg::I_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_seg   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
            r_seg   <= n_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s    <= n_s;
        r_y0   <= n_y0;
        r_dy   <= n_dy;
        r_down <= n_down;
        r_diff <= n_diff;
        r_dx   <= n_dx;
        r_rem  <= n_rem;
        r_low  <= n_low;
        r_quo  <= n_quo;
        r_duty <= n_duty;
    end

    assign o_done = r_done;
    assign o_duty = r_duty;

    a_rem_below_dx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == alc_pkg::I_DIV) |-> (r_rem < r_dx))
        else $error("divider remainder out of range");

    a_seg_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == alc_pkg::I_SEARCH) |-> (r_seg <= LAST_SEG))
        else $error("segment index past last segment");

endmodule

`default_nettype wire

[rtl/ambient_light_dimming_curve_top.sv]
// channel   direction  handshake          payload
// input     in         i_valid / o_stall  i_light_sample[15:0]
// output    out        o_valid / i_stall  o_duty_value[8:0], o_window_total[18:0]
// config    in         APB write/read     paddr[2:0], pwdata[31:0], prdata[31:0]
//
// a sum off either end of the curve takes the shortest path from the accepting edge to o_valid;
// a used word adds a window read-modify-write, and the rest is the segment search at one
// curve point a cycle and a 9-step restoring divider
// reset is synchronous and active low; it clears the window, the sum and the phase
// the input is stalled while a word is in work and reopens the cycle after its result loads;
// one finished result can wait in the output register under stall while the next is taken
`timescale 1ns / 1ps
`default_nettype none

module ambient_light_dimming_curve_top #(
    parameter int WINDOW_DEPTH = alc_pkg::WINDOW_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [alc_pkg::SAMPLE_W-1:0]   i_light_sample,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [alc_pkg::DUTY_W-1:0]          o_duty_value,
    output logic [alc_pkg::TOTAL_W-1:0]         o_window_total,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [alc_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [alc_pkg::DATA_W-1:0]     pwdata,
    output logic [alc_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);

    localparam int SUM_W = alc_pkg::SAMPLE_W + $clog2(WINDOW_DEPTH);

    alc_pkg::t_top_state r_state, n_state;
    alc_pkg::t_cfg       r_cfg;
    logic [alc_pkg::SAMPLE_W-1:0] r_sample;
    logic                         r_out_valid, n_out_valid;
    logic [alc_pkg::DUTY_W-1:0]   r_duty_out;
    logic [alc_pkg::TOTAL_W-1:0]  r_total_out;

    logic                         accept;
    logic                         win_done;
    logic [SUM_W-1:0]             win_sum;
    logic                         int_done;
    logic [alc_pkg::DUTY_W-1:0]   int_duty;
    logic                         int_start;
    logic                         out_free;
    logic                         load;
    logic                         cfg_wr;
    logic [alc_pkg::SUM_MAX_W-1:0] sum_wide;

    assign o_stall   = (r_state != alc_pkg::T_IDLE);
    assign accept    = i_valid && !o_stall;
    assign out_free  = !r_out_valid || !i_stall;
    assign int_start = (r_state == alc_pkg::T_WIN) && win_done;
    assign sum_wide  = alc_pkg::SUM_MAX_W'(win_sum);

    alc_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SUM_W        (SUM_W)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_sample (r_sample),
        .i_cfg    (r_cfg),
        .o_done   (win_done),
        .o_sum    (win_sum)
    );

    alc_interp #(
        .SUM_W (SUM_W)
    ) u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (int_start),
        .i_sum   (win_sum),
        .o_done  (int_done),
        .o_duty  (int_duty)
    );

    always_comb begin
        n_state = r_state;
        load    = 1'b0;
        case (r_state)
            alc_pkg::T_IDLE: begin
                if (accept) n_state = alc_pkg::T_WIN;
            end
            alc_pkg::T_WIN: begin
                if (win_done) n_state = alc_pkg::T_INTERP;
            end
            alc_pkg::T_INTERP: begin
                if (int_done) begin
                    if (out_free) begin
                        load    = 1'b1;
                        n_state = alc_pkg::T_IDLE;
                    end else begin
                        n_state = alc_pkg::T_HOLD;
                    end
                end
            end
            alc_pkg::T_HOLD: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_state = alc_pkg::T_IDLE;
                end
            end
            default: n_state = alc_pkg::T_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_stall) n_out_valid = 1'b0;
        if (load) n_out_valid = 1'b1;
    end

    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= alc_pkg::T_IDLE;
            r_out_valid      <= 1'b0;
            r_cfg.ceiling    <= alc_pkg::CEILING_RST;
            r_cfg.deadband   <= alc_pkg::DEADBAND_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                case (paddr[2])
                    alc_pkg::REG_CEILING:  r_cfg.ceiling  <= pwdata[alc_pkg::SAMPLE_W-1:0];
                    alc_pkg::REG_DEADBAND: r_cfg.deadband <= pwdata[alc_pkg::DB_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_sample <= i_light_sample;
        if (load) begin
            r_duty_out  <= int_duty;
            r_total_out <= sum_wide[alc_pkg::TOTAL_W-1:0];
        end
    end

    always_comb begin
        case (paddr[2])
            alc_pkg::REG_CEILING:
                prdata = alc_pkg::DATA_W'(r_cfg.ceiling);
            alc_pkg::REG_DEADBAND:
                prdata = alc_pkg::DATA_W'(r_cfg.deadband);
            default:
                prdata = '0;
        endcase
    end

    assign pready         = 1'b1;
    assign o_valid        = r_out_valid;
    assign o_duty_value   = r_duty_out;
    assign o_window_total = r_total_out;

    a_win_done_in_win: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        win_done |-> (r_state == alc_pkg::T_WIN))
        else $error("window finished outside its step");

    a_int_done_in_interp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int_done |-> (r_state == alc_pkg::T_INTERP))
        else $error("interpolator finished outside its step");

endmodule

`default_nettype wire
